@@ rtl/cat_pkg.sv @@
// Shared types, codes and helpers of the counter / alarm tick unit.
// No dependencies; imported by every module of the block.
package cat_pkg;

    // Input commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ARM    = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    // Result kinds (0..3 are alarm actions)
    localparam logic [2:0] KIND_ACK = 3'd4;

    // Alarm action code that ticks another counter
    localparam logic [1:0] ACT_INCR = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_LIMIT0  = 3'd0;
    localparam logic [2:0] CFG_LIMIT1  = 3'd1;
    localparam logic [2:0] CFG_LIMIT2  = 3'd2;
    localparam logic [2:0] CFG_LIMIT3  = 3'd3;
    localparam logic [2:0] CFG_CNT_MAP = 3'd4;
    localparam logic [2:0] CFG_ACT_MAP = 3'd5;
    localparam logic [2:0] CFG_CAS_MAP = 3'd6;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int MAP_IDX_W = 4;   // alarm index width seen by the 2-bit-per-alarm maps
    localparam int MAP_SLOTS = 8;   // alarms that the 16-bit maps cover

    // Cascade work list
    localparam int WORK_DEPTH = 8;
    localparam int WL_IW      = 3;
    localparam int WL_CW      = 4;

    // Controller -> datapath
    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic tick;     // advance the current counter
        logic scan;     // process the current alarm
        logic pop;      // take next counter from the work list
        logic flush;    // hand out the held result as last
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic ctr_ok;     // current counter exists
        logic scan_stall; // result ready but no room downstream
        logic scan_last;  // current alarm is the highest one
        logic wl_empty;
        logic pend_v;     // a result is held back
        logic out_free;   // output register can load
    } t_dp_stat;

    // Two-bit field of a map for alarm a; alarms past the map read as zero.
    function automatic logic [1:0] map_pair(input logic [CFG_W-1:0] map,
                                            input logic [MAP_IDX_W-1:0] a);
        logic [1:0] r;
        r = 2'd0;
        if (a < MAP_IDX_W'(MAP_SLOTS)) begin
            r = map[2*a +: 2];
        end
        return r;
    endfunction

endpackage

@@ rtl/cat_ctrl.sv @@
// Controller of the counter / alarm tick unit: sequences tick, alarm scan,
// cascade pops and the final result. Depends on cat_pkg.
module cat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_cmd,
    output logic              o_in_ready,
    output cat_pkg::t_dp_cmd  o_dp_cmd,
    input  cat_pkg::t_dp_stat i_dp_stat
);
    import cat_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TICK  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_dp_cmd.accept = 1'b1;
                    unique case (i_cmd) inside
                        CMD_TICK:           n_state = S_TICK;
                        CMD_ARM, CMD_CANCEL: n_state = S_FLUSH;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                o_dp_cmd.tick = 1'b1;
                n_state = i_dp_stat.ctr_ok ? S_SCAN : S_POP;
            end
            S_SCAN: begin
                o_dp_cmd.scan = 1'b1;
                if (!i_dp_stat.scan_stall && i_dp_stat.scan_last) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                o_dp_cmd.pop = 1'b1;
                n_state = i_dp_stat.wl_empty ? S_FLUSH : S_TICK;
            end
            S_FLUSH: begin
                o_dp_cmd.flush = 1'b1;
                if (!i_dp_stat.pend_v || i_dp_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/cat_datapath.sv @@
// Datapath of the counter / alarm tick unit: config registers, counters,
// alarm table, cascade work list, held result and output register. Uses cat_pkg.
module cat_datapath #(
    parameter int ALARMS       = 8,
    parameter int COUNTERS     = 4,
    parameter int TIME_WIDTH   = 16,
    parameter int RESULT_LIMIT = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cat_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]                 i_cmd,
    input  logic [1:0]                 i_counter_sel,
    input  logic [2:0]                 i_alarm_sel,
    input  logic [15:0]                i_first_delay,
    input  logic [15:0]                i_repeat_period,
    input  cat_pkg::t_dp_cmd           i_dp_cmd,
    output cat_pkg::t_dp_stat          o_dp_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [2:0]                 o_kind,
    output logic [2:0]                 o_alarm_num,
    output logic [15:0]                o_counter_value,
    output logic                       o_dropped,
    output logic                       o_last
);
    import cat_pkg::*;

    localparam int AIW = (ALARMS > 1) ? $clog2(ALARMS) : 1;
    localparam int CIW = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
    localparam int NW  = $clog2(RESULT_LIMIT + 1);
    localparam int TW  = TIME_WIDTH;

    // configuration
    logic [CFG_W-1:0] r_limit [4];
    logic [CFG_W-1:0] r_cnt_map;
    logic [CFG_W-1:0] r_act_map;
    logic [CFG_W-1:0] r_cas_map;

    // state
    logic [TW-1:0]     r_time [COUNTERS];
    logic [TW-1:0]     r_rem  [ALARMS];
    logic [TW-1:0]     r_per  [ALARMS];
    logic [ALARMS-1:0] r_en;
    logic [1:0]        r_wl [WORK_DEPTH];
    logic [WL_IW-1:0]  r_wl_head;
    logic [WL_IW-1:0]  r_wl_tail;
    logic [WL_CW-1:0]  r_wl_cnt;

    // per-item work registers
    logic [1:0]    r_ctr;
    logic [TW-1:0] r_tval;
    logic [AIW-1:0] r_aidx;
    logic [NW-1:0] r_nres;
    logic          r_drop;

    // held result (last flag known only once the next one shows up)
    logic          r_pend_v;
    logic [2:0]    r_pend_kind;
    logic [2:0]    r_pend_alarm;
    logic [15:0]   r_pend_cval;

    // output register
    logic          r_out_v;
    logic [2:0]    r_out_kind;
    logic [2:0]    r_out_alarm;
    logic [15:0]   r_out_cval;
    logic          r_out_drop;
    logic          r_out_last;

    logic [CIW-1:0]       cidx;
    logic                 ctr_ok;
    logic [TW-1:0]        t_inc;
    logic [TW-1:0]        t_next;
    logic [MAP_IDX_W-1:0] a4;
    logic [1:0]           a_ctr;
    logic [1:0]           a_act;
    logic [1:0]           a_tgt;
    logic                 match;
    logic [TW-1:0]        rem_dec;
    logic                 expire;
    logic                 room;
    logic                 emit;
    logic                 out_free;
    logic                 stall;
    logic                 scan_go;
    logic                 push;
    logic                 wl_full;
    logic                 load_out;
    logic                 flush_go;
    logic [AIW-1:0]       asel;
    logic                 asel_ok;

    assign cidx    = CIW'(r_ctr);
    assign ctr_ok  = (r_ctr < COUNTERS);
    assign t_inc   = r_time[cidx] + 1'b1;
    assign t_next  = (32'(t_inc) >= 32'(r_limit[r_ctr])) ? '0 : t_inc;

    assign a4      = MAP_IDX_W'(r_aidx);
    assign a_ctr   = map_pair(r_cnt_map, a4);
    assign a_act   = map_pair(r_act_map, a4);
    assign a_tgt   = map_pair(r_cas_map, a4);
    assign match   = r_en[r_aidx] && (a_ctr == r_ctr);
    assign rem_dec = r_rem[r_aidx] - 1'b1;
    assign expire  = match && (rem_dec == '0);
    assign room    = (r_nres < RESULT_LIMIT);
    assign emit    = expire && room;
    assign out_free = !r_out_v || i_out_ready;
    assign stall   = emit && r_pend_v && !out_free;
    assign scan_go = i_dp_cmd.scan && !stall;
    assign wl_full = (r_wl_cnt == WL_CW'(WORK_DEPTH));
    assign push    = emit && (a_act == ACT_INCR) && (a_tgt < COUNTERS);
    assign flush_go = i_dp_cmd.flush && r_pend_v && out_free;
    assign load_out = (scan_go && emit && r_pend_v) || flush_go;

    assign asel    = AIW'(i_alarm_sel);
    assign asel_ok = (i_alarm_sel < ALARMS);

    always_comb begin
        o_dp_stat.ctr_ok     = ctr_ok;
        o_dp_stat.scan_stall = stall;
        o_dp_stat.scan_last  = (r_aidx == AIW'(ALARMS - 1));
        o_dp_stat.wl_empty   = (r_wl_cnt == '0);
        o_dp_stat.pend_v     = r_pend_v;
        o_dp_stat.out_free   = out_free;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_limit[i] <= '1;
            end
            r_cnt_map <= '0;
            r_act_map <= '0;
            r_cas_map <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                CFG_LIMIT0, CFG_LIMIT1, CFG_LIMIT2, CFG_LIMIT3:
                    r_limit[i_cfg_idx[1:0]] <= i_cfg_data;
                CFG_CNT_MAP: r_cnt_map <= i_cfg_data;
                CFG_ACT_MAP: r_act_map <= i_cfg_data;
                CFG_CAS_MAP: r_cas_map <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // counters, alarms, work list, held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COUNTERS; i++) begin
                r_time[i] <= '0;
            end
            for (int i = 0; i < ALARMS; i++) begin
                r_rem[i] <= '0;
                r_per[i] <= '0;
            end
            r_en      <= '0;
            r_wl_head <= '0;
            r_wl_tail <= '0;
            r_wl_cnt  <= '0;
            r_nres    <= '0;
            r_drop    <= 1'b0;
            r_pend_v  <= 1'b0;
            r_aidx    <= '0;
            r_ctr     <= '0;
        end else begin
            if (i_dp_cmd.accept) begin
                case (i_cmd) inside
                    CMD_TICK: begin
                        r_ctr     <= i_counter_sel;
                        r_nres    <= '0;
                        r_drop    <= 1'b0;
                        r_wl_head <= '0;
                        r_wl_tail <= '0;
                        r_wl_cnt  <= '0;
                    end
                    CMD_ARM, CMD_CANCEL: begin
                        if (asel_ok) begin
                            if (i_cmd == CMD_ARM) begin
                                r_rem[asel] <= TW'(i_first_delay);
                                r_per[asel] <= TW'(i_repeat_period);
                                r_en[asel]  <= 1'b1;
                            end else begin
                                r_en[asel]  <= 1'b0;
                            end
                        end
                        r_pend_v     <= 1'b1;
                        r_pend_kind  <= KIND_ACK;
                        r_pend_alarm <= i_alarm_sel;
                        r_pend_cval  <= '0;
                        r_drop       <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (i_dp_cmd.tick && ctr_ok) begin
                r_time[cidx] <= t_next;
                r_tval       <= t_next;
                r_aidx       <= '0;
            end

            if (scan_go) begin
                if (match) begin
                    if (expire) begin
                        if (r_per[r_aidx] == '0) begin
                            r_en[r_aidx]  <= 1'b0;
                            r_rem[r_aidx] <= '0;
                        end else begin
                            r_rem[r_aidx] <= r_per[r_aidx];
                        end
                    end else begin
                        r_rem[r_aidx] <= rem_dec;
                    end
                end
                if (expire && !room) begin
                    r_drop <= 1'b1;
                end
                if (emit) begin
                    r_pend_v     <= 1'b1;
                    r_pend_kind  <= {1'b0, a_act};
                    r_pend_alarm <= 3'(r_aidx);
                    r_pend_cval  <= 16'(r_tval);
                    r_nres       <= r_nres + 1'b1;
                end
                if (push) begin
                    if (wl_full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_wl[r_wl_tail] <= a_tgt;
                        r_wl_tail       <= r_wl_tail + 1'b1;
                    end
                end
                r_aidx <= (r_aidx == AIW'(ALARMS - 1)) ? '0 : r_aidx + 1'b1;
            end

            if (i_dp_cmd.pop && (r_wl_cnt != '0)) begin
                r_ctr     <= r_wl[r_wl_head];
                r_wl_head <= r_wl_head + 1'b1;
            end

            // count update: a push and a pop never share a cycle
            if (scan_go && push && !wl_full) begin
                r_wl_cnt <= r_wl_cnt + 1'b1;
            end else if (i_dp_cmd.pop && (r_wl_cnt != '0)) begin
                r_wl_cnt <= r_wl_cnt - 1'b1;
            end

            if (flush_go) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (load_out) begin
            r_out_v     <= 1'b1;
            r_out_kind  <= r_pend_kind;
            r_out_alarm <= r_pend_alarm;
            r_out_cval  <= r_pend_cval;
            r_out_drop  <= flush_go && r_drop;
            r_out_last  <= flush_go;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_kind          = r_out_kind;
    assign o_alarm_num     = r_out_alarm;
    assign o_counter_value = r_out_cval;
    assign o_dropped       = r_out_drop;
    assign o_last          = r_out_last;

endmodule

@@ rtl/counter_alarm_tick_unit_top.sv @@
// Top level of the counter / alarm tick unit.
// Instantiates cat_ctrl and cat_datapath; uses cat_pkg.
//
// Keeps COUNTERS tick counters and ALARMS countdown alarms. A tick item (cmd 0)
// advances one counter (wrapping to zero at its limit register) and then walks
// all alarms, one alarm per cycle, counting down every enabled alarm mapped to
// that counter. An expiring alarm reloads from its period (or disables itself
// when the period is zero) and reports its action code as a result item; an
// increment action queues a tick of another counter on an 8-entry work list,
// which is drained within the same tick item. Results carry the counter value
// after the tick; the final result of an item has last set, plus dropped when
// results beyond RESULT_LIMIT or work list entries were lost. A tick that
// expires nothing gives no result. Arm (cmd 1) and cancel (cmd 2) items update
// one alarm and give one acknowledge result; cmd 3 is ignored.
// Timing: one item at a time. An arm or cancel item updates one alarm, then
// hands out its acknowledge. A tick item runs a counter tick and an alarm scan
// for the first counter and for each cascade tick; the single shared alarm
// scan walks one alarm per cycle. A result that cannot leave because the
// output is stalled holds the scan.
// Configuration: write index 0..3 counter limits, 4 alarm-to-counter map,
// 5 alarm action map, 6 cascade target map (2 bits per alarm).
module counter_alarm_tick_unit_top #(
    parameter int ALARMS       = 8,
    parameter int COUNTERS     = 4,
    parameter int TIME_WIDTH   = 16,
    parameter int RESULT_LIMIT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [cat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cat_pkg::CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [1:0]                    i_counter_sel,
    input  logic [2:0]                    i_alarm_sel,
    input  logic [15:0]                   i_first_delay,
    input  logic [15:0]                   i_repeat_period,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_kind,
    output logic [2:0]                    o_alarm_num,
    output logic [15:0]                   o_counter_value,
    output logic                          o_dropped,
    output logic                          o_last
);
    import cat_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    cat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .o_dp_cmd   (dp_cmd),
        .i_dp_stat  (dp_stat)
    );

    cat_datapath #(
        .ALARMS       (ALARMS),
        .COUNTERS     (COUNTERS),
        .TIME_WIDTH   (TIME_WIDTH),
        .RESULT_LIMIT (RESULT_LIMIT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_counter_sel   (i_counter_sel),
        .i_alarm_sel     (i_alarm_sel),
        .i_first_delay   (i_first_delay),
        .i_repeat_period (i_repeat_period),
        .i_dp_cmd        (dp_cmd),
        .o_dp_stat       (dp_stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_alarm_num     (o_alarm_num),
        .o_counter_value (o_counter_value),
        .o_dropped       (o_dropped),
        .o_last          (o_last)
    );

endmodule

@@ rtl/cat_checker.sv @@
// Port-level checks for the counter / alarm tick unit, bound to the top level.
// Depends on cat_pkg and counter_alarm_tick_unit_top.
module cat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_cmd,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_kind,
    input logic [15:0] o_counter_value,
    input logic        o_dropped,
    input logic        o_last
);
    import cat_pkg::*;

    // arm/cancel keeps the block busy for the acknowledge
    a_ack_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_ARM || i_cmd == CMD_CANCEL)
        |=> !o_in_ready)
        else $error("input taken again right after arm/cancel");

    // acknowledge is always a lone, clean, final item
    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ACK
        |-> o_last && !o_dropped && o_counter_value == 16'd0)
        else $error("malformed acknowledge");

    // loss flag only on the final result
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> o_last)
        else $error("dropped set on a non-final result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready
        |=> o_out_valid && $stable(o_kind) && $stable(o_counter_value) && $stable(o_last))
        else $error("result changed while stalled");

endmodule

bind counter_alarm_tick_unit_top cat_checker u_cat_checker (.*);

@@ tb/tb_counter_alarm_tick_unit_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for counter_alarm_tick_unit_top: directed and random items.
// Results are checked in order against an in-bench copy of the counters and alarms.
// Depends on rtl/cat_pkg.sv and rtl/counter_alarm_tick_unit_top.sv.
module tb_counter_alarm_tick_unit_top;
    import cat_pkg::*;

    localparam int ALARM_CNT   = 8;
    localparam int RESULT_CAP  = 64;       // matches RESULT_LIMIT of the block
    localparam int SETTLE_CYC  = 64;       // > one tick walk that gives no result
    localparam int HOLD_AT     = 40;       // accepted items before the long output stall
    localparam int HOLD_CYC    = 400;
    localparam int QUIET_FROM  = 150;      // window of accepted items with no idling
    localparam int QUIET_TO    = 200;
    localparam int PHASE_ITEMS = 65;
    localparam int LIMIT_CYC   = 1500000;

    localparam logic [1:0] CMD_NONE     = 2'd3;   // unused command, ignored
    localparam logic [1:0] ACT_TASK     = 2'd0;
    localparam logic [1:0] ACT_CALLBACK = 2'd1;
    localparam logic [1:0] ACT_EVENT    = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  ctr;
        logic [2:0]  alarm;
        logic [15:0] delay;
        logic [15:0] period;
    } t_alarm_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  alarm;
        logic [15:0] cval;
        logic        dropped;
        logic        last;
    } t_alarm_event;

    // DUT signals; every input starts at a known value
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_cmd = '0;
    logic [1:0]           i_counter_sel = '0;
    logic [2:0]           i_alarm_sel = '0;
    logic [15:0]          i_first_delay = '0;
    logic [15:0]          i_repeat_period = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [2:0]           o_kind;
    logic [2:0]           o_alarm_num;
    logic [15:0]          o_counter_value;
    logic                 o_dropped;
    logic                 o_last;

    counter_alarm_tick_unit_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_counter_sel   (i_counter_sel),
        .i_alarm_sel     (i_alarm_sel),
        .i_first_delay   (i_first_delay),
        .i_repeat_period (i_repeat_period),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_alarm_num     (o_alarm_num),
        .o_counter_value (o_counter_value),
        .o_dropped       (o_dropped),
        .o_last          (o_last)
    );

    // Mirror of the block's registers and state
    logic [15:0]  ctr_limit [4] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    logic [15:0]  cnt_map = '0;
    logic [15:0]  act_map = '0;
    logic [15:0]  cas_map = '0;
    logic [15:0]  ctr_time [4] = '{default: '0};
    logic [15:0]  alarm_rem [ALARM_CNT] = '{default: '0};
    logic [15:0]  alarm_per [ALARM_CNT] = '{default: '0};
    logic         alarm_en [ALARM_CNT] = '{default: 1'b0};
    logic [1:0]   cascade_q [$];          // counters still to tick in this item
    t_alarm_event owed [$];               // results the block still has to deliver
    t_alarm_cmd   cmd_backlog [$];        // items not yet put on the input

    int  n_sent = 0;
    int  n_taken = 0;
    int  errors = 0;
    int  cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;
    logic quiet;

    assign quiet = (n_taken >= QUIET_FROM) && (n_taken < QUIET_TO);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // One counter tick and the alarm walk that follows it
    task automatic tick_counter(input logic [1:0] c, inout int n, inout bit lost);
        logic [15:0]  t;
        logic [15:0]  rem;
        logic [1:0]   act;
        t_alarm_event ev;
        t = ctr_time[c] + 16'd1;
        if (t >= ctr_limit[c]) t = '0;
        ctr_time[c] = t;
        for (int a = 0; a < ALARM_CNT; a++) begin
            if (cnt_map[2*a +: 2] != c || !alarm_en[a]) continue;
            rem = alarm_rem[a] - 16'd1;
            if (rem == '0) begin
                if (alarm_per[a] == '0) alarm_en[a] = 1'b0;
                else rem = alarm_per[a];
                alarm_rem[a] = rem;
                act = act_map[2*a +: 2];
                if (n >= RESULT_CAP) begin
                    // past the result cap: alarm still updated, nothing reported
                    lost = 1'b1;
                    continue;
                end
                ev = '{kind: {1'b0, act}, alarm: 3'(a), cval: t, dropped: 1'b0, last: 1'b0};
                owed.push_back(ev);
                n++;
                if (act == ACT_INCR) begin
                    if (cascade_q.size() < WORK_DEPTH) cascade_q.push_back(cas_map[2*a +: 2]);
                    else lost = 1'b1;
                end
            end else begin
                alarm_rem[a] = rem;
            end
        end
    endtask

    // Expected results of one accepted item, appended to owed
    task automatic process_item(input t_alarm_cmd it);
        int n;
        bit lost;
        n = 0;
        lost = 1'b0;
        case (it.cmd)
            CMD_TICK: begin
                cascade_q.delete();
                tick_counter(it.ctr, n, lost);
                while (cascade_q.size() > 0) tick_counter(cascade_q.pop_front(), n, lost);
            end
            CMD_ARM, CMD_CANCEL: begin
                if (it.cmd == CMD_ARM) begin
                    alarm_rem[it.alarm] = it.delay;
                    alarm_per[it.alarm] = it.period;
                    alarm_en[it.alarm]  = 1'b1;
                end else begin
                    alarm_en[it.alarm] = 1'b0;   // values kept
                end
                owed.push_back('{kind: KIND_ACK, alarm: it.alarm, cval: 16'd0,
                                 dropped: 1'b0, last: 1'b0});
                n = 1;
            end
            default: ;
        endcase
        if (n > 0) begin
            owed[owed.size()-1].dropped = lost;
            owed[owed.size()-1].last    = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void queue_item(input logic [1:0] cmd, input logic [1:0] ctr,
                                       input logic [2:0] alarm, input logic [15:0] delay,
                                       input logic [15:0] period);
        cmd_backlog.push_back('{cmd: cmd, ctr: ctr, alarm: alarm, delay: delay,
                                period: period});
        n_sent++;
    endfunction

    // Mostly short delays and periods so that alarms fire often
    function automatic t_alarm_cmd rand_item();
        t_alarm_cmd it;
        int r;
        it.ctr   = 2'($urandom);
        it.alarm = 3'($urandom);
        r = $urandom_range(99);
        if (r < 55)      it.cmd = CMD_TICK;
        else if (r < 78) it.cmd = CMD_ARM;
        else if (r < 94) it.cmd = CMD_CANCEL;
        else             it.cmd = CMD_NONE;
        r = $urandom_range(99);
        if (r < 80)      it.delay = 16'($urandom_range(4, 1));
        else if (r < 96) it.delay = 16'($urandom);
        else             it.delay = 16'd0;
        r = $urandom_range(99);
        if (r < 60)      it.period = 16'($urandom_range(4, 1));
        else if (r < 80) it.period = 16'd0;
        else             it.period = 16'($urandom);
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_LIMIT0:  ctr_limit[0] = val;
            CFG_LIMIT1:  ctr_limit[1] = val;
            CFG_LIMIT2:  ctr_limit[2] = val;
            CFG_LIMIT3:  ctr_limit[3] = val;
            CFG_CNT_MAP: cnt_map = val;
            CFG_ACT_MAP: act_map = val;
            CFG_CAS_MAP: cas_map = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [15:0] lim0, input logic [15:0] lim1,
                               input logic [15:0] lim2, input logic [15:0] lim3,
                               input logic [15:0] cnt, input logic [15:0] act,
                               input logic [15:0] cas);
        write_reg(CFG_LIMIT0, lim0);
        write_reg(CFG_LIMIT1, lim1);
        write_reg(CFG_LIMIT2, lim2);
        write_reg(CFG_LIMIT3, lim3);
        write_reg(CFG_CNT_MAP, cnt);
        write_reg(CFG_ACT_MAP, act);
        write_reg(CFG_CAS_MAP, cas);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender pause: every item taken, every result in, then let a silent tick walk finish
    task automatic wait_drained();
        while (n_sent != n_taken || owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Item driver: new payload only at the falling edge after the previous item was taken
    always @(negedge i_clk) begin
        t_alarm_cmd nxt;
        bit         go;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            go = cmd_backlog.size() > 0 && (quiet || $urandom_range(99) >= 24);
            if (go) begin
                nxt = cmd_backlog.pop_front();
                i_in_valid      <= 1'b1;
                i_cmd           <= nxt.cmd;
                i_counter_sel   <= nxt.ctr;
                i_alarm_sel     <= nxt.alarm;
                i_first_delay   <= nxt.delay;
                i_repeat_period <= nxt.period;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, one long stall while items keep coming
    always @(negedge i_clk) begin
        bit rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && n_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYC;
            rdy = 1'b0;
        end else begin
            rdy = quiet || $urandom_range(99) >= 24;
        end
        i_out_ready <= rdy;
    end

    // Monitor: check results first, then record the item taken at this edge
    always @(posedge i_clk) begin
        t_alarm_event want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (owed.size() == 0) begin
                    $error("unexpected result: kind %0d alarm %0d value %0d",
                           o_kind, o_alarm_num, o_counter_value);
                    errors++;
                end else begin
                    want = owed.pop_front();
                    check_field("kind", 16'(want.kind), 16'(o_kind));
                    check_field("alarm_num", 16'(want.alarm), 16'(o_alarm_num));
                    check_field("counter_value", want.cval, o_counter_value);
                    check_field("dropped", 16'(want.dropped), 16'(o_dropped));
                    check_field("last", 16'(want.last), 16'(o_last));
                end
            end
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                process_item('{cmd: i_cmd, ctr: i_counter_sel, alarm: i_alarm_sel,
                               delay: i_first_delay, period: i_repeat_period});
                n_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYC) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Counter 0 wraps at 3, counter 2 at 1, counter 3 has limit zero.
        // Alarms 0..3 sit on counters 0..3; alarm 3 increments counter 1.
        load_config(16'd3, 16'hFFFF, 16'd1, 16'd0,
                    {2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0},
                    {ACT_EVENT, ACT_TASK, ACT_CALLBACK, ACT_EVENT,
                     ACT_INCR, ACT_EVENT, ACT_CALLBACK, ACT_TASK},
                    {2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0});
        queue_item(CMD_TICK, 2'd0, 3'd0, 16'd0, 16'd0);           // nothing armed
        queue_item(CMD_ARM, 2'd0, 3'd0, 16'd1, 16'd0);            // single shot
        queue_item(CMD_TICK, 2'd0, 3'd0, 16'd0, 16'd0);
        queue_item(CMD_TICK, 2'd0, 3'd0, 16'd0, 16'd0);           // now disabled
        queue_item(CMD_ARM, 2'd0, 3'd1, 16'd2, 16'd1);
        queue_item(CMD_TICK, 2'd1, 3'd0, 16'd0, 16'd0);
        queue_item(CMD_TICK, 2'd1, 3'd0, 16'd0, 16'd0);
        queue_item(CMD_ARM, 2'd0, 3'd3, 16'd1, 16'd1);
        queue_item(CMD_TICK, 2'd3, 3'd0, 16'd0, 16'd0);           // cascade into counter 1
        queue_item(CMD_ARM, 2'd3, 3'd2, 16'hFFFF, 16'hFFFF);
        queue_item(CMD_CANCEL, 2'd0, 3'd2, 16'd0, 16'd0);
        queue_item(CMD_ARM, 2'd0, 3'd0, 16'd0, 16'd0);            // zero delay wraps
        queue_item(CMD_ARM, 2'd0, 3'd4, 16'd5, 16'd3);
        queue_item(CMD_ARM, 2'd0, 3'd4, 16'd1, 16'd2);            // overwrite while enabled
        queue_item(CMD_TICK, 2'd0, 3'd0, 16'd0, 16'd0);
        queue_item(CMD_NONE, 2'd3, 3'd7, 16'hFFFF, 16'hFFFF);     // ignored
        queue_item(CMD_TICK, 2'd2, 3'd0, 16'd0, 16'd0);
        wait_drained();

        // Runaway cascade: every alarm on counter 0 increments counter 0, so the
        // work list fills and the result cap is hit in one tick item
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        for (int a = 0; a < ALARM_CNT; a++) queue_item(CMD_ARM, 2'd0, 3'(a), 16'd1, 16'd1);
        queue_item(CMD_TICK, 2'd0, 3'd0, 16'd0, 16'd0);
        wait_drained();

        // Random phases: largest limits, smallest limits, then random settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'($urandom), 16'($urandom), 16'($urandom));
                1: load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'h0000, 16'h0000, 16'h0000);
                2: load_config(16'($urandom_range(9, 2)), 16'($urandom_range(9, 2)),
                               16'($urandom_range(9, 2)), 16'($urandom_range(9, 2)),
                               16'($urandom), 16'($urandom), 16'($urandom));
                default: load_config(16'($urandom_range(9, 2)), 16'($urandom_range(9, 2)),
                                     16'($urandom_range(9, 2)), 16'($urandom_range(9, 2)),
                                     16'hFFFF, 16'($urandom), 16'hFFFF);
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                cmd_backlog.push_back(rand_item());
                n_sent++;
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/cat_pkg.sv
rtl/cat_ctrl.sv
rtl/cat_datapath.sv
rtl/counter_alarm_tick_unit_top.sv
rtl/cat_checker.sv
tb/tb_counter_alarm_tick_unit_top.sv
